### design/aes256_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// AES-256 block encryption - assertion macros
// Concurrent checks clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef AES256_BLOCK_ENCRYPT_DEFINES_SVH
`define AES256_BLOCK_ENCRYPT_DEFINES_SVH

`ifndef SYNTHESIS

`define AES256_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("aes256 assertion failed");

`define AES256_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("aes256 latency assertion failed");

`define AES256_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes256 sequence assertion failed");

`else

`define AES256_ASSERT_NOW(label, expr)
`define AES256_ASSERT_DELAY(label, ante, n, cons)
`define AES256_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/aes256_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 block encryption - package
// Word types, register indexes, S-box, round constants and round functions.
// ----------------------------------------------------------------------------
package aes256_pkg;

  localparam int NUM_ROUNDS = 14;
  localparam int LATENCY    = NUM_ROUNDS + 1;

  typedef struct packed {
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } block_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } cipher_t;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_KEY_WORD0 = 2'd0;
  localparam reg_index_t REG_KEY_WORD1 = 2'd1;
  localparam reg_index_t REG_KEY_WORD2 = 2'd2;
  localparam reg_index_t REG_KEY_WORD3 = 2'd3;

  localparam logic [7:0] GF_REDUCE  = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [8] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte k of the state sits at bits 127-8k downward; column-major layout
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a, b, d, e, all;
    a = col[31:24];
    b = col[23:16];
    d = col[15:8];
    e = col[7:0];
    all = a ^ b ^ d ^ e;
    return {a ^ all ^ xtime(a ^ b), b ^ all ^ xtime(b ^ d),
            d ^ all ^ xtime(d ^ e), e ^ all ^ xtime(e ^ a)};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32 * c -: 32] = mix_column(s[127 - 32 * c -: 32]);
    end
    return t;
  endfunction

endpackage

### design/aes256_round_cell.sv
// ----------------------------------------------------------------------------
// AES-256 round cell
// One cipher round plus one step of the key schedule; registers the state,
// the sliding eight-word key window and the valid bit for the next cell.
// ----------------------------------------------------------------------------
module aes256_round_cell #(
  parameter int ROUND = 1,
  parameter bit LAST  = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  logic [127:0]   state_in,
  input  logic [255:0]   key_in,
  output logic           valid_out,
  output logic [127:0]   state_out,
  output logic [255:0]   key_out
);
  import aes256_pkg::*;

  localparam int         RC_IDX = (ROUND + 1) / 2;
  localparam bit         ROTATE = (ROUND % 2) == 1;
  localparam logic [7:0] RC     = RCON[RC_IDX[2:0]];

  logic [127:0] shifted;
  logic [127:0] state_next;
  logic [31:0]  temp;
  logic [31:0]  n0, n1, n2, n3;
  logic [255:0] key_next;

  // round key is window words 4..7
  always_comb begin
    shifted    = sub_shift(state_in);
    state_next = (LAST ? shifted : mix_columns(shifted)) ^ key_in[127:0];
  end

  always_comb begin
    if (ROTATE) begin
      temp = sub_word({key_in[23:0], key_in[31:24]}) ^ {RC, 24'h0};
    end else begin
      temp = sub_word(key_in[31:0]);
    end
    n0       = key_in[255:224] ^ temp;
    n1       = key_in[223:192] ^ n0;
    n2       = key_in[191:160] ^ n1;
    n3       = key_in[159:128] ^ n2;
    key_next = {key_in[127:0], n0, n1, n2, n3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    state_out <= state_next;
    key_out   <= key_next;
  end

endmodule

### design/aes256_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-256 block encryption - top level
// Pipeline: input stage plus 14 round cells, each registered, from start to done.
// Throughput: one block per cycle; a new block may start every cycle while busy is low.
// Each round cell carries its own key schedule step, so blocks never wait.
// Synchronous reset clears the key registers to zero and flushes all valid bits.
// busy is high only during reset; done is high for one cycle per block.
// ----------------------------------------------------------------------------
module aes256_block_encrypt (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  aes256_pkg::block_t  block,
  output logic                done,
  output aes256_pkg::cipher_t result,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [63:0]         wr_data
);
  import aes256_pkg::*;

  `include "aes256_block_encrypt_defines.svh"

  logic [63:0]  key_word0, key_word1, key_word2, key_word3;
  logic [255:0] key_all;

  logic         valid [NUM_ROUNDS + 1];
  logic [127:0] state [NUM_ROUNDS + 1];
  logic [255:0] window [NUM_ROUNDS];

  assign busy    = rst;
  assign key_all = {key_word0, key_word1, key_word2, key_word3};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_KEY_WORD0: key_word0 <= wr_data;
        REG_KEY_WORD1: key_word1 <= wr_data;
        REG_KEY_WORD2: key_word2 <= wr_data;
        REG_KEY_WORD3: key_word3 <= wr_data;
        default: ;
      endcase
    end
  end

  // input stage: initial key add
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= start && !busy;
    end
    state[0]  <= {block.block_hi, block.block_lo} ^ key_all[255:128];
    window[0] <= key_all;
  end

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    if (r == NUM_ROUNDS) begin : g_last
      aes256_round_cell #(
        .ROUND (r),
        .LAST  (1'b1)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (valid[r - 1]),
        .state_in  (state[r - 1]),
        .key_in    (window[r - 1]),
        .valid_out (valid[r]),
        .state_out (state[r]),
        .key_out   ()
      );
    end else begin : g_mid
      aes256_round_cell #(
        .ROUND (r),
        .LAST  (1'b0)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (valid[r - 1]),
        .state_in  (state[r - 1]),
        .key_in    (window[r - 1]),
        .valid_out (valid[r]),
        .state_out (state[r]),
        .key_out   (window[r])
      );
    end
  end

  assign done             = valid[NUM_ROUNDS];
  assign result.cipher_hi = state[NUM_ROUNDS][127:64];
  assign result.cipher_lo = state[NUM_ROUNDS][63:0];

  `AES256_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
  `AES256_ASSERT_NOW(a_no_spurious_done, !done || $past(start && !busy, LATENCY))
  `AES256_ASSERT_NEXT(a_valid_chain, valid[0], valid[1])
  `AES256_ASSERT_NOW(a_clean_after_reset, !$fell(rst) || (!done && !valid[0]))

endmodule
